// File: hw/rtl/rnsd_pkg.sv
// Package for the RNS divide-and-round-by-last-modulus block.
// Beat types, register map and widths; no dependencies.
package rnsd_pkg;

  localparam int FIELD_W           = 60;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_ADDR_W        = 6;
  localparam int DEF_RESIDUE_COUNT = 4;
  localparam int DEF_MODULUS_BITS  = 60;
  localparam int MAX_LANES         = 3;

  typedef enum logic [2:0] {
    REG_MODULUS_0      = 3'd0,
    REG_MODULUS_1      = 3'd1,
    REG_MODULUS_2      = 3'd2,
    REG_MODULUS_LAST   = 3'd3,
    REG_INV_LAST_MOD_0 = 3'd4,
    REG_INV_LAST_MOD_1 = 3'd5,
    REG_INV_LAST_MOD_2 = 3'd6,
    REG_ROUND_MODE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [FIELD_W-1:0] residue_0;
    logic [FIELD_W-1:0] residue_1;
    logic [FIELD_W-1:0] residue_2;
    logic [FIELD_W-1:0] residue_last;
    logic               end_of_poly;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_0;
    logic [FIELD_W-1:0] result_1;
    logic [FIELD_W-1:0] result_2;
    logic               end_of_poly_out;
  } out_beat_t;

endpackage

// File: hw/rtl/rnsd_if.sv
// Valid/ready stream interfaces for coefficient and result beats.
// Depends on rnsd_pkg.
interface rnsd_in_if;
  logic                valid;
  logic                ready;
  rnsd_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rnsd_out_if;
  logic                valid;
  logic                ready;
  rnsd_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/rnsd_modred.sv
// Pipelined restoring remainder a mod q, one quotient bit per stage.
// Modulus is a static config value; no dependencies.
module rnsd_modred #(
  parameter int IW = 60,
  parameter int QW = 60
) (
  input  logic          clk,
  input  logic [IW-1:0] a,
  input  logic [QW-1:0] q,
  output logic [QW-1:0] rem
);

  logic [QW-1:0] st_rem [1:IW];
  logic [IW-1:0] st_a   [1:IW];
  logic [QW-1:0] rem_next [1:IW];

  always_comb begin
    logic [QW:0]   trial;
    logic [QW-1:0] prev_rem;
    logic [IW-1:0] prev_a;
    for (int k = 0; k < IW; k++) begin
      prev_rem = (k == 0) ? '0 : st_rem[k];
      prev_a   = (k == 0) ? a  : st_a[k];
      trial    = {prev_rem, prev_a[IW-1-k]};
      if (trial >= {1'b0, q}) begin
        trial = trial - {1'b0, q};
      end
      rem_next[k+1] = trial[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= IW; k++) begin
      st_rem[k] <= rem_next[k];
      st_a[k]   <= (k == 1) ? a : st_a[k-1];
    end
  end

  // modulus 0 or 1: everything is zero
  assign rem = (q[QW-1:1] == '0) ? '0 : st_rem[IW];

endmodule

// File: hw/rtl/rnsd_modmul.sv
// Pipelined shift-and-add modular product a*b mod q, one bit of b per stage.
// Operands below q; q static config. No dependencies.
module rnsd_modmul #(
  parameter int QW = 60
) (
  input  logic          clk,
  input  logic [QW-1:0] a,
  input  logic [QW-1:0] b,
  input  logic [QW-1:0] q,
  output logic [QW-1:0] prod
);

  logic [QW-1:0] st_r [1:QW];
  logic [QW-1:0] st_a [1:QW];
  logic [QW-1:0] st_b [1:QW];
  logic [QW-1:0] r_next [1:QW];

  always_comb begin
    logic [QW:0]   t;
    logic [QW-1:0] pr;
    logic [QW-1:0] pa;
    logic [QW-1:0] pb;
    for (int k = 0; k < QW; k++) begin
      pr = (k == 0) ? '0 : st_r[k];
      pa = (k == 0) ? a  : st_a[k];
      pb = (k == 0) ? b  : st_b[k];
      t  = {pr, 1'b0};
      if (t >= {1'b0, q}) begin
        t = t - {1'b0, q};
      end
      if (pb[QW-1-k]) begin
        t = t + {1'b0, pa};
        if (t >= {1'b0, q}) begin
          t = t - {1'b0, q};
        end
      end
      r_next[k+1] = t[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= QW; k++) begin
      st_r[k] <= r_next[k];
      st_a[k] <= (k == 1) ? a : st_a[k-1];
      st_b[k] <= (k == 1) ? b : st_b[k-1];
    end
  end

  assign prod = (q[QW-1:1] == '0) ? '0 : st_r[QW];

endmodule

// File: hw/rtl/rnsd_lane.sv
// One kept-modulus lane: reduce operands, subtract, multiply by inverse.
// Depends on rnsd_modred and rnsd_modmul.
module rnsd_lane #(
  parameter int RW = 60,
  parameter int QW = 60
) (
  input  logic          clk,
  input  logic [RW-1:0] x,
  input  logic [RW-1:0] xl,
  input  logic [QW-1:0] half,
  input  logic          round_mode,
  input  logic [QW-1:0] q,
  input  logic [QW-1:0] inv,
  output logic [QW-1:0] res
);

  logic [QW-1:0] x_red, xl_red, half_red, inv_red;
  logic [QW-1:0] x_d1, t_d1;
  logic [QW-1:0] diff;

  rnsd_modred #(.IW(RW), .QW(QW)) u_red_x (
    .clk(clk), .a(x), .q(q), .rem(x_red));
  rnsd_modred #(.IW(RW), .QW(QW)) u_red_xl (
    .clk(clk), .a(xl), .q(q), .rem(xl_red));
  rnsd_modred #(.IW(RW), .QW(QW)) u_red_half (
    .clk(clk), .a(RW'(half)), .q(q), .rem(half_red));
  rnsd_modred #(.IW(RW), .QW(QW)) u_red_inv (
    .clk(clk), .a(RW'(inv)), .q(q), .rem(inv_red));

  function automatic logic [QW-1:0] submod(input logic [QW-1:0] a,
                                           input logic [QW-1:0] b,
                                           input logic [QW-1:0] m);
    submod = (a >= b) ? (a - b) : (a + (m - b));
  endfunction

  always_ff @(posedge clk) begin
    x_d1 <= x_red;
    t_d1 <= round_mode ? submod(xl_red, half_red, q) : xl_red;
    diff <= submod(x_d1, t_d1, q);
  end

  rnsd_modmul #(.QW(QW)) u_mul (
    .clk(clk), .a(inv_red), .b(diff), .q(q), .prod(res));

endmodule

// File: hw/rtl/rnsd_outq.sv
// Result queue behind the fixed-latency pipeline, with a registered output.
// Depends on rnsd_pkg. Space is reserved upstream by a credit count.
module rnsd_outq #(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rnsd_pkg::out_beat_t push_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rnsd_pkg::out_beat_t out_data
);

  localparam int PW = $clog2(DEPTH);

  rnsd_pkg::out_beat_t mem [0:DEPTH-1];
  logic [PW:0] wr_ptr, rd_ptr;
  logic        pop;

  assign pop = (wr_ptr != rd_ptr) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[PW-1:0]] <= push_data;
    end
    if (pop) begin
      out_data <= mem[rd_ptr[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr    <= rd_ptr + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/rns_divide_round_by_last_modulus_unit.sv
// Top level: RNS rescale, division of a coefficient by the last modulus, floored or rounded.
// Depends on rnsd_pkg, rnsd_if, rnsd_modred, rnsd_lane, rnsd_outq.
//
//  channel   dir  beat
//  coef_in   in   residue_0..2, residue_last, end_of_poly
//  coef_out  out  result_0..2, end_of_poly_out
//  apb       in   8 config registers at 8*i, 64-bit data
//
// One coefficient per cycle while coef_in.ready is high, with the queue behind the
// pipeline; lanes work at RW = max(60, MODULUS_BITS) bits, and the pipeline depth
// is set by the bit-per-stage remainder and product pipelines.
// Pipeline never stalls; results land in a queue, and a credit count keeps
// coef_in.ready high as long as the queue has room for every beat in flight.
// Reset (rst, synchronous) clears credits, beat valid tracking, queue pointers and config registers.
module rns_divide_round_by_last_modulus_unit #(
  parameter int RESIDUE_COUNT = rnsd_pkg::DEF_RESIDUE_COUNT,
  parameter int MODULUS_BITS  = rnsd_pkg::DEF_MODULUS_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  rnsd_in_if.sink                         coef_in,
  rnsd_out_if.source                      coef_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rnsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rnsd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rnsd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int FW    = rnsd_pkg::FIELD_W;
  localparam int MB    = MODULUS_BITS;
  localparam int NL    = RESIDUE_COUNT - 1;
  localparam int RW    = (FW > MB) ? FW : MB;
  localparam int LAT   = FW + 1 + RW + 2 + MB;
  localparam int DEPTH = 1 << $clog2(LAT + 2);
  localparam int CW    = $clog2(DEPTH) + 1;

  // ---------------- config registers ----------------
  logic [MB-1:0] q_reg   [0:2];
  logic [MB-1:0] inv_reg [0:2];
  logic [MB-1:0] q_last;
  logic          round_mode;
  rnsd_pkg::reg_idx_t reg_idx;
  logic          cfg_wr;

  assign reg_idx = rnsd_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        q_reg[i]   <= MB'(2);
        inv_reg[i] <= MB'(1);
      end
      q_last     <= MB'(2);
      round_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        rnsd_pkg::REG_MODULUS_0:      q_reg[0]   <= pwdata[MB-1:0];
        rnsd_pkg::REG_MODULUS_1:      q_reg[1]   <= pwdata[MB-1:0];
        rnsd_pkg::REG_MODULUS_2:      q_reg[2]   <= pwdata[MB-1:0];
        rnsd_pkg::REG_MODULUS_LAST:   q_last     <= pwdata[MB-1:0];
        rnsd_pkg::REG_INV_LAST_MOD_0: inv_reg[0] <= pwdata[MB-1:0];
        rnsd_pkg::REG_INV_LAST_MOD_1: inv_reg[1] <= pwdata[MB-1:0];
        rnsd_pkg::REG_INV_LAST_MOD_2: inv_reg[2] <= pwdata[MB-1:0];
        rnsd_pkg::REG_ROUND_MODE:     round_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rnsd_pkg::REG_MODULUS_0:      prdata = rnsd_pkg::CFG_DATA_W'(q_reg[0]);
      rnsd_pkg::REG_MODULUS_1:      prdata = rnsd_pkg::CFG_DATA_W'(q_reg[1]);
      rnsd_pkg::REG_MODULUS_2:      prdata = rnsd_pkg::CFG_DATA_W'(q_reg[2]);
      rnsd_pkg::REG_MODULUS_LAST:   prdata = rnsd_pkg::CFG_DATA_W'(q_last);
      rnsd_pkg::REG_INV_LAST_MOD_0: prdata = rnsd_pkg::CFG_DATA_W'(inv_reg[0]);
      rnsd_pkg::REG_INV_LAST_MOD_1: prdata = rnsd_pkg::CFG_DATA_W'(inv_reg[1]);
      rnsd_pkg::REG_INV_LAST_MOD_2: prdata = rnsd_pkg::CFG_DATA_W'(inv_reg[2]);
      rnsd_pkg::REG_ROUND_MODE:     prdata = rnsd_pkg::CFG_DATA_W'(round_mode);
      default:                      prdata = '0;
    endcase
  end

  // half of last modulus; zero when last modulus is below two
  logic [MB-1:0] half;
  assign half = (q_last[MB-1:1] == '0) ? '0 : (q_last >> 1);

  // ---------------- credits and beat tracking ----------------
  logic          in_acc, out_acc;
  logic [CW-1:0] credit;
  logic [LAT-1:0] vld_sr, eop_sr;

  assign in_acc        = coef_in.valid && coef_in.ready;
  assign out_acc       = coef_out.valid && coef_out.ready;
  assign coef_in.ready = (credit < CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      vld_sr <= '0;
    end else begin
      credit <= credit + CW'(in_acc) - CW'(out_acc);
      vld_sr <= {vld_sr[LAT-2:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    eop_sr <= {eop_sr[LAT-2:0], coef_in.data.end_of_poly};
  end

  // ---------------- last residue: reduce, then round offset ----------------
  logic [MB-1:0] xl_red;
  logic [MB:0]   xl_sum;
  logic [MB-1:0] xl_adj;

  rnsd_modred #(.IW(FW), .QW(MB)) u_red_last (
    .clk(clk), .a(coef_in.data.residue_last), .q(q_last), .rem(xl_red));

  assign xl_sum = {1'b0, xl_red} + {1'b0, half};

  always_ff @(posedge clk) begin
    if (!round_mode) begin
      xl_adj <= xl_red;
    end else if (xl_sum >= {1'b0, q_last}) begin
      xl_adj <= MB'(xl_sum - {1'b0, q_last});
    end else begin
      xl_adj <= xl_sum[MB-1:0];
    end
  end

  // kept residues wait for the last-residue path
  logic [FW-1:0] x_in [0:2];
  logic [FW-1:0] x_dly [0:2][0:FW];

  assign x_in[0] = coef_in.data.residue_0;
  assign x_in[1] = coef_in.data.residue_1;
  assign x_in[2] = coef_in.data.residue_2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      x_dly[i][0] <= x_in[i];
      for (int k = 1; k <= FW; k++) begin
        x_dly[i][k] <= x_dly[i][k-1];
      end
    end
  end

  // ---------------- lanes ----------------
  logic [FW-1:0] lane_res [0:2];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    if (g < NL) begin : g_kept
      logic [MB-1:0] res;
      rnsd_lane #(.RW(RW), .QW(MB)) u_lane (
        .clk(clk), .x(RW'(x_dly[g][FW])), .xl(RW'(xl_adj)), .half(half),
        .round_mode(round_mode), .q(q_reg[g]), .inv(inv_reg[g]), .res(res));
      assign lane_res[g] = FW'(res);
    end else begin : g_unused
      assign lane_res[g] = '0;
    end
  end

  // ---------------- merge and queue ----------------
  rnsd_pkg::out_beat_t merged;

  always_comb begin
    merged.result_0        = lane_res[0];
    merged.result_1        = lane_res[1];
    merged.result_2        = lane_res[2];
    merged.end_of_poly_out = eop_sr[LAT-1];
  end

  rnsd_outq #(.DEPTH(DEPTH)) u_outq (
    .clk(clk), .rst(rst), .push(vld_sr[LAT-1]), .push_data(merged),
    .out_valid(coef_out.valid), .out_ready(coef_out.ready),
    .out_data(coef_out.data));

endmodule

// File: hw/rtl/rnsd_chk.sv
// Port-level checker for the rescale unit, bound to the top level.
// Depends on rnsd_pkg and the top level's ports.
module rnsd_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rnsd_pkg::out_beat_t out_data,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("unit not empty and ready after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("config port wait state");

endmodule

bind rns_divide_round_by_last_modulus_unit rnsd_chk u_rnsd_chk (
  .clk(clk), .rst(rst), .in_ready(coef_in.ready),
  .out_valid(coef_out.valid), .out_ready(coef_out.ready),
  .out_data(coef_out.data), .pready(pready));
